// ----- src/totp_code_generator_top_defines.svh -----
// ------------------------------------------------------------------------
// totp_code_generator_top_defines.svh
// Assertion macros shared by the checker of the TOTP generator.
// ------------------------------------------------------------------------
`ifndef TOTP_CODE_GENERATOR_TOP_DEFINES_SVH
`define TOTP_CODE_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOTP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("TOTP checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TOTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("TOTP checker: next-cycle property failed");

`endif

// ----- src/totp_pkg.sv -----
// ------------------------------------------------------------------------
// totp_pkg
// Types, constants, SHA-256 helpers and a power-of-ten table for the TOTP generator.
// ------------------------------------------------------------------------
`default_nettype none

package totp_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [15:0][WordW-1:0] block_t;
  typedef logic [7:0][WordW-1:0]  hash_t;

  typedef struct packed {
    logic   start;
    block_t block;
    hash_t  h_in;
  } sha_req_t;

  localparam logic CmdLoad     = 1'b0;
  localparam logic CmdGenerate = 1'b1;

  localparam logic [1:0] RegKeyLength  = 2'd0;
  localparam logic [1:0] RegDigitCount = 2'd1;
  localparam logic [1:0] RegTimeOrigin = 2'd2;
  localparam logic [1:0] RegTimeStep   = 2'd3;

  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
  localparam logic [31:0] PadWord  = 32'h80000000;
  localparam logic [31:0] CtrBits  = 32'd576;
  localparam logic [31:0] HashBits = 32'd768;

  localparam hash_t InitHash = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                                32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [29:0] pow10(input logic [3:0] d);
    case (d)
      4'd0: pow10 = 30'd1;
      4'd1: pow10 = 30'd10;
      4'd2: pow10 = 30'd100;
      4'd3: pow10 = 30'd1000;
      4'd4: pow10 = 30'd10000;
      4'd5: pow10 = 30'd100000;
      4'd6: pow10 = 30'd1000000;
      4'd7: pow10 = 30'd10000000;
      4'd8: pow10 = 30'd100000000;
      4'd9: pow10 = 30'd1000000000;
      default: pow10 = 30'd1;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; 6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/totp_code_generator_top.sv -----
// A generate word runs a bit-serial division of the elapsed time by the step,
// four SHA-256 compressions on the single round unit, and, for up to nine
// digits, a modulo on the same divider. A load word leaves the input ready;
// a rejected generate goes straight to the output state.
// The input is not ready while a code is in work.
// ------------------------------------------------------------------------
// totp_code_generator_top
// TOTP code generator, HMAC-SHA256 with dynamic truncation.
// ------------------------------------------------------------------------
`default_nettype none

module totp_code_generator_top #(
  parameter int unsigned KEY_WORDS  = 16,
  parameter int unsigned MIN_DIGITS = 6,
  parameter int unsigned MAX_DIGITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [3:0]  key_index_i,
  input  wire logic [31:0] key_word_i,
  input  wire logic [63:0] cur_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [30:0]      code_o,
  output logic             status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int unsigned KiW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StIpad  = 4'd2;
  localparam logic [3:0] StCtr   = 4'd3;
  localparam logic [3:0] StOpad  = 4'd4;
  localparam logic [3:0] StInner = 4'd5;
  localparam logic [3:0] StTrunc = 4'd6;
  localparam logic [3:0] StMod   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [31:0] key_q [KEY_WORDS];
  logic [6:0]  key_len_q;
  logic [3:0]  digits_q;
  logic [63:0] origin_q;
  logic [15:0] step_q;
  logic [63:0] ctr_q, ctr_d;
  totp_pkg::hash_t inner_q, inner_d;
  logic [30:0] res_q, res_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  logic [30:0] code_q, code_d;
  logic        status_q, status_d;

  logic        accept, bad_cfg;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quot;
  logic [31:0] div_divisor, div_rem;
  totp_pkg::sha_req_t sha_req;
  logic        sha_done;
  totp_pkg::hash_t sha_hash;
  totp_pkg::block_t key_blk;
  logic [255:0] mac;
  logic [3:0]  off;
  logic [30:0] bin;

  totp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  totp_sha_core u_sha (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sha_req),
    .done_o(sha_done),
    .hash_o(sha_hash)
  );

  always_comb begin
    key_blk = '0;
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        if ((j < int'(KEY_WORDS)) && ((4 * j + b) < int'(key_len_q))) begin
          key_blk[j][31-8*b -: 8] = key_q[j][31-8*b -: 8];
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      mac[255-32*i -: 32] = sha_hash[i];
    end
    off = sha_hash[7][3:0];
    bin = mac[254-8*off -: 31];
  end

  assign accept  = in_valid_i && in_ready_o;
  assign bad_cfg = (key_len_q == 7'd0) || (key_len_q > 7'd64) ||
                   (digits_q < 4'(MIN_DIGITS)) || (digits_q > 4'(MAX_DIGITS));

  always_comb begin
    state_d      = state_q;
    ctr_d        = ctr_q;
    inner_d      = inner_q;
    res_d        = res_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    code_d       = code_q;
    status_d     = status_q;
    div_start    = 1'b0;
    div_dividend = cur_time_i - origin_q;
    div_divisor  = {16'd0, step_q};
    sha_req      = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept && (command_i == totp_pkg::CmdGenerate)) begin
          if (bad_cfg) begin
            res_d   = '0;
            err_d   = 1'b1;
            state_d = StOut;
          end else begin
            err_d     = 1'b0;
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          ctr_d         = div_quot;
          sha_req.start = 1'b1;
          for (int j = 0; j < 16; j++) begin
            sha_req.block[j] = key_blk[j] ^ totp_pkg::IpadWord;
          end
          sha_req.h_in = totp_pkg::InitHash;
          state_d      = StIpad;
        end
      end
      StIpad: begin
        if (sha_done) begin
          sha_req.start     = 1'b1;
          sha_req.block[0]  = ctr_q[63:32];
          sha_req.block[1]  = ctr_q[31:0];
          sha_req.block[2]  = totp_pkg::PadWord;
          sha_req.block[15] = totp_pkg::CtrBits;
          sha_req.h_in      = sha_hash;
          state_d           = StCtr;
        end
      end
      StCtr: begin
        if (sha_done) begin
          inner_d       = sha_hash;
          sha_req.start = 1'b1;
          for (int j = 0; j < 16; j++) begin
            sha_req.block[j] = key_blk[j] ^ totp_pkg::OpadWord;
          end
          sha_req.h_in = totp_pkg::InitHash;
          state_d      = StOpad;
        end
      end
      StOpad: begin
        if (sha_done) begin
          sha_req.start = 1'b1;
          for (int j = 0; j < 8; j++) begin
            sha_req.block[j] = inner_q[j];
          end
          sha_req.block[8]  = totp_pkg::PadWord;
          sha_req.block[15] = totp_pkg::HashBits;
          sha_req.h_in      = sha_hash;
          state_d           = StInner;
        end
      end
      StInner: begin
        if (sha_done) begin
          state_d = StTrunc;
        end
      end
      StTrunc: begin
        if (digits_q > 4'd9) begin
          res_d   = bin;
          state_d = StOut;
        end else begin
          div_start    = 1'b1;
          div_dividend = {33'd0, bin};
          div_divisor  = {2'd0, totp_pkg::pow10(digits_q)};
          state_d      = StMod;
        end
      end
      StMod: begin
        if (div_done) begin
          res_d   = div_rem[30:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          code_d      = res_q;
          status_d    = err_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      key_len_q   <= 7'd0;
      digits_q    <= 4'd6;
      origin_q    <= '0;
      step_q      <= 16'd30;
      for (int j = 0; j < int'(KEY_WORDS); j++) begin
        key_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          totp_pkg::RegKeyLength:  key_len_q <= cfg_data_i[6:0];
          totp_pkg::RegDigitCount: digits_q  <= cfg_data_i[3:0];
          totp_pkg::RegTimeOrigin: origin_q  <= cfg_data_i;
          totp_pkg::RegTimeStep:   step_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (accept && (command_i == totp_pkg::CmdLoad) &&
          ({28'd0, key_index_i} < 32'(KEY_WORDS))) begin
        key_q[key_index_i[KiW-1:0]] <= key_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q    <= ctr_d;
    inner_q  <= inner_d;
    res_q    <= res_d;
    err_q    <= err_d;
    code_q   <= code_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ----- src/totp_sha_core.sv -----
// ------------------------------------------------------------------------
// totp_sha_core
// SHA-256 compression of one block, one round per cycle.
// ------------------------------------------------------------------------
`default_nettype none

module totp_sha_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire totp_pkg::sha_req_t req_i,
  output logic                   done_o,
  output totp_pkg::hash_t        hash_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [5:0]           round_q, round_d;
  totp_pkg::block_t     w_q, w_d;
  totp_pkg::hash_t      v_q, v_d;
  totp_pkg::hash_t      hin_q, hin_d;
  totp_pkg::hash_t      hash_q, hash_d;
  logic [31:0]          t1, t2, big_s0, big_s1, ch, maj, sig0, sig1, w_new;

  always_comb begin
    big_s1 = totp_pkg::rotr(v_q[4], 6) ^ totp_pkg::rotr(v_q[4], 11) ^
             totp_pkg::rotr(v_q[4], 25);
    big_s0 = totp_pkg::rotr(v_q[0], 2) ^ totp_pkg::rotr(v_q[0], 13) ^
             totp_pkg::rotr(v_q[0], 22);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1     = v_q[7] + big_s1 + ch + totp_pkg::round_k(round_q) + w_q[0];
    t2     = big_s0 + maj;
    sig0   = totp_pkg::rotr(w_q[1], 7) ^ totp_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sig1   = totp_pkg::rotr(w_q[14], 17) ^ totp_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new  = w_q[0] + sig0 + w_q[9] + sig1;

    busy_d  = busy_q;
    done_d  = 1'b0;
    round_d = round_q;
    w_d     = w_q;
    v_d     = v_q;
    hin_d   = hin_q;
    hash_d  = hash_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      round_d = '0;
      w_d     = req_i.block;
      v_d     = req_i.h_in;
      hin_d   = req_i.h_in;
    end else if (busy_q) begin
      for (int j = 0; j < 15; j++) begin
        w_d[j] = w_q[j+1];
      end
      w_d[15] = w_new;
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      round_d = round_q + 6'd1;
      if (round_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        for (int j = 0; j < 8; j++) begin
          hash_d[j] = hin_q[j] + v_d[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    v_q    <= v_d;
    hin_q  <= hin_d;
    hash_q <= hash_d;
  end

  assign done_o = done_q;
  assign hash_o = hash_q;

endmodule

`default_nettype wire

// ----- src/totp_div.sv -----
// ------------------------------------------------------------------------
// totp_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ------------------------------------------------------------------------
`default_nettype none

module totp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o,
  output logic [31:0]      rem_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [32:0] trial, diff;

  always_comb begin
    trial  = {rem_q, quot_q[63]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d  = diff[31:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- src/totp_checker.sv -----
// ------------------------------------------------------------------------
// totp_checker
// Port-level checks of the TOTP generator, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none
`include "totp_code_generator_top_defines.svh"

module totp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        command_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [30:0] code_o,
  input wire logic        status_o
);

  `TOTP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `TOTP_ASSERT_SAME(a_err_zero, out_valid_o && status_o, code_o == 31'd0)
  `TOTP_ASSERT_NEXT(a_gen_busy, in_valid_i && in_ready_o && command_i, !in_ready_o)
  `TOTP_ASSERT_NEXT(a_load_free, in_valid_i && in_ready_o && !command_i, in_ready_o)

endmodule

bind totp_code_generator_top totp_checker u_totp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .command_i  (command_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .code_o     (code_o),
  .status_o   (status_o)
);

`default_nettype wire
